// ===== hdl/cosp_pkg.sv =====
// package for the option stream parser: phase codes, byte kinds, queue entry type
// no dependencies
package cosp_pkg;

  typedef enum logic [3:0] {
    PH_CODE, PH_HEAD, PH_DX1, PH_DX2H, PH_DX2L, PH_LX1, PH_LX2H, PH_LX2L,
    PH_VALUE, PH_PAYLOAD, PH_DISCARD
  } phase_t;

  localparam logic [2:0] KIND_CODE    = 3'd0;
  localparam logic [2:0] KIND_HEADER  = 3'd1;
  localparam logic [2:0] KIND_VALUE   = 3'd2;
  localparam logic [2:0] KIND_MARKER  = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD = 3'd4;
  localparam logic [2:0] KIND_DISCARD = 3'd5;

  localparam logic [7:0] MARKER_BYTE = 8'hFF;
  localparam logic [3:0] NIB_EXT1 = 4'd13;
  localparam logic [3:0] NIB_EXT2 = 4'd14;
  localparam logic [3:0] NIB_BAD  = 4'd15;
  localparam logic [8:0] EXT2_BASE = 9'd269;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  byte_out;
    logic [15:0] opt_num;
    logic [15:0] option_length;
    logic [15:0] value_index;
    logic        option_done;
    logic        frame_done;
    logic        parse_status;
    logic [15:0] body_offset;
  } result_t;

endpackage

// ===== hdl/cosp_if.sv =====
// valid/ready channel interface carrying a payload of parameterised width
// depends on nothing
interface cosp_if #(parameter int W = 9) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cosp_front.sv =====
// front part: phase tracking and classification of each byte into a result
// depends on cosp_pkg
module cosp_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output cosp_pkg::result_t res
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  cosp_pkg::phase_t          phase_r, phase_nxt;
  logic [7:0]                ext_high_r, ext_high_nxt;
  logic [3:0]                len_nib_r, len_nib_nxt;
  logic [15:0]               num_r, num_nxt;
  logic [15:0]               len_r, len_nxt;
  logic [15:0]               left_r, left_nxt;
  logic [POSITION_BITS-1:0]  pos_r, pos_inc;
  logic [POSITION_BITS-1:0]  mark_r, mark_nxt;
  logic                      err_r, err_nxt;

  logic [3:0]  dn, ln;
  logic [17:0] dsum;
  logic [16:0] lval, ext2;
  logic        fail, odone, dapply;
  logic [16:0] dval;
  logic [3:0]  tl_nib;
  logic [POSITION_BITS-1:0] off_pos;

  assign pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  assign dn = data_byte[7:4];
  assign ln = data_byte[3:0];
  assign ext2 = 17'(cosp_pkg::EXT2_BASE) + {1'b0, ext_high_r, data_byte};

  always_comb begin
    phase_nxt = phase_r;
    ext_high_nxt = ext_high_r;
    len_nib_nxt = len_nib_r;
    num_nxt = num_r;
    len_nxt = len_r;
    left_nxt = left_r;
    mark_nxt = mark_r;
    err_nxt = err_r;
    fail = 1'b0;
    odone = 1'b0;
    dapply = 1'b0;
    dval = '0;
    tl_nib = len_nib_r;
    lval = '0;
    res = '0;
    res.byte_out = data_byte;
    res.byte_kind = cosp_pkg::KIND_DISCARD;
    case (phase_r)
      cosp_pkg::PH_CODE: begin
        res.byte_kind = cosp_pkg::KIND_CODE;
        phase_nxt = cosp_pkg::PH_HEAD;
      end
      cosp_pkg::PH_HEAD: begin
        res.byte_kind = cosp_pkg::KIND_HEADER;
        if (data_byte == cosp_pkg::MARKER_BYTE) begin
          res.byte_kind = cosp_pkg::KIND_MARKER;
          mark_nxt = pos_inc;
          phase_nxt = cosp_pkg::PH_PAYLOAD;
        end else begin
          len_nib_nxt = ln;
          tl_nib = ln;
          len_nxt = '0;
          if (dn == cosp_pkg::NIB_BAD || ln == cosp_pkg::NIB_BAD) fail = 1'b1;
          else if (dn == cosp_pkg::NIB_EXT1) phase_nxt = cosp_pkg::PH_DX1;
          else if (dn == cosp_pkg::NIB_EXT2) phase_nxt = cosp_pkg::PH_DX2H;
          else begin
            dapply = 1'b1;
            dval = 17'(dn);
          end
        end
      end
      cosp_pkg::PH_DX1: begin
        res.byte_kind = cosp_pkg::KIND_HEADER;
        dapply = 1'b1;
        dval = 17'(data_byte) + 17'd13;
      end
      cosp_pkg::PH_DX2H, cosp_pkg::PH_LX2H: begin
        res.byte_kind = cosp_pkg::KIND_HEADER;
        ext_high_nxt = data_byte;
        phase_nxt = (phase_r == cosp_pkg::PH_DX2H) ? cosp_pkg::PH_DX2L
                                                   : cosp_pkg::PH_LX2L;
      end
      cosp_pkg::PH_DX2L: begin
        res.byte_kind = cosp_pkg::KIND_HEADER;
        dapply = 1'b1;
        dval = ext2;
      end
      cosp_pkg::PH_LX1, cosp_pkg::PH_LX2L: begin
        res.byte_kind = cosp_pkg::KIND_HEADER;
        lval = (phase_r == cosp_pkg::PH_LX1) ? 17'(data_byte) + 17'd13 : ext2;
        if (lval[16]) fail = 1'b1;
        else begin
          len_nxt = lval[15:0];
          if (lval[15:0] == '0) begin
            odone = 1'b1;
            phase_nxt = cosp_pkg::PH_HEAD;
          end else begin
            left_nxt = lval[15:0];
            phase_nxt = cosp_pkg::PH_VALUE;
          end
        end
      end
      cosp_pkg::PH_VALUE: begin
        res.byte_kind = cosp_pkg::KIND_VALUE;
        res.value_index = len_r - left_r;
        left_nxt = (left_r != '0) ? left_r - 16'd1 : left_r;
        if (left_nxt == '0) begin
          odone = 1'b1;
          phase_nxt = cosp_pkg::PH_HEAD;
        end
      end
      cosp_pkg::PH_PAYLOAD: res.byte_kind = cosp_pkg::KIND_PAYLOAD;
      default: res.byte_kind = cosp_pkg::KIND_DISCARD;
    endcase

    // delta completes: accumulate number then take the length nibble
    dsum = {2'b00, num_r} + {1'b0, dval};
    if (dapply) begin
      if (dsum[17:16] != 2'b00) fail = 1'b1;
      else begin
        num_nxt = dsum[15:0];
        if (tl_nib == cosp_pkg::NIB_EXT1) phase_nxt = cosp_pkg::PH_LX1;
        else if (tl_nib == cosp_pkg::NIB_EXT2) phase_nxt = cosp_pkg::PH_LX2H;
        else begin
          len_nxt = 16'(tl_nib);
          if (tl_nib == '0) begin
            odone = 1'b1;
            phase_nxt = cosp_pkg::PH_HEAD;
          end else begin
            left_nxt = 16'(tl_nib);
            phase_nxt = cosp_pkg::PH_VALUE;
          end
        end
      end
    end

    if (fail) begin
      err_nxt = 1'b1;
      odone = 1'b0;
      phase_nxt = cosp_pkg::PH_DISCARD;
    end
    if (last_byte && phase_nxt != cosp_pkg::PH_HEAD && phase_nxt != cosp_pkg::PH_PAYLOAD)
      err_nxt = 1'b1;

    if (res.byte_kind == cosp_pkg::KIND_HEADER || res.byte_kind == cosp_pkg::KIND_VALUE) begin
      res.opt_num = num_nxt;
      res.option_length = len_nxt;
    end
    res.option_done = odone;
    res.frame_done = last_byte;
    res.parse_status = err_nxt;
    off_pos = (phase_nxt == cosp_pkg::PH_PAYLOAD) ? mark_nxt : pos_inc;
    if (last_byte && !err_nxt) begin
      if (POSITION_BITS > 16)
        res.body_offset = (off_pos > POSITION_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(off_pos);
      else
        res.body_offset = 16'(off_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && last_byte)) begin
      phase_r <= cosp_pkg::PH_CODE;
      ext_high_r <= '0;
      len_nib_r <= '0;
      num_r <= '0;
      len_r <= '0;
      left_r <= '0;
      pos_r <= '0;
      mark_r <= '0;
      err_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      ext_high_r <= ext_high_nxt;
      len_nib_r <= len_nib_nxt;
      num_r <= num_nxt;
      len_r <= len_nxt;
      left_r <= left_nxt;
      pos_r <= pos_inc;
      mark_r <= mark_nxt;
      err_r <= err_nxt;
    end
  end

  a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
    (take && phase_r == cosp_pkg::PH_VALUE) |-> (left_r != '0))
    else $error("value phase with nothing left");

endmodule

// ===== hdl/cosp_queue.sv =====
// two-entry result queue between classification and the output channel
// depends on cosp_pkg
module cosp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cosp_pkg::result_t push_data,
  output logic              can_push,
  output logic              pop_valid,
  input  logic              pop,
  output cosp_pkg::result_t pop_data
);

  cosp_pkg::result_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign can_push = (cnt_r != 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && cnt_r == 2'd2))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && cnt_r == 2'd0))
    else $error("pop from empty queue");

endmodule

// ===== hdl/coap_option_stream_parser_unit.sv =====
// channel | dir | payload
// in_ch   | in  | data_byte[7:0], last_byte
// out_ch  | out | result_t fields, byte_kind .. body_offset
// one byte per cycle sustained while the queue has room; each result is registered in the queue before out valid
// front classifies in the accepting cycle, a two-entry queue decouples the output
// in ready drops only while the queue is full; synchronous active-low reset
// depends on cosp_pkg, cosp_if, cosp_front, cosp_queue
module coap_option_stream_parser_unit #(
  parameter int POSITION_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  cosp_if.sink   in_ch,
  cosp_if.source out_ch
);

  cosp_pkg::result_t res, qout;
  logic take, can_push;

  assign in_ch.ready = can_push;
  assign take = in_ch.valid && can_push;

  cosp_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk, .rst_n, .take,
    .data_byte(in_ch.data[7:0]), .last_byte(in_ch.data[8]), .res
  );

  cosp_queue u_queue (
    .clk, .rst_n, .push(take), .push_data(res), .can_push,
    .pop_valid(out_ch.valid), .pop(out_ch.valid && out_ch.ready), .pop_data(qout)
  );

  assign out_ch.data = qout;

endmodule
